@@ src/rcbc_pkg.sv @@
// Shared types and constants for the RC bind and control packet sequencer.
// Used by every module in src; depends on nothing.
package rcbc_pkg;

    localparam int PKT_BYTES = 9;

    // configuration register indexes
    localparam logic CFG_VARIANT = 1'b0;
    localparam logic CFG_ADDRESS = 1'b1;

    // receiver variants
    localparam logic [2:0] VAR_BASE   = 3'd0;
    localparam logic [2:0] VAR_WALKER = 3'd1;
    localparam logic [2:0] VAR_QUAD   = 3'd2;
    localparam logic [2:0] VAR_XINX   = 3'd3;
    localparam logic [2:0] VAR_NIHUI  = 3'd4;

    // address actions
    localparam logic [1:0] ADDR_NONE = 2'd0;
    localparam logic [1:0] ADDR_BIND = 2'd1;
    localparam logic [1:0] ADDR_DATA = 2'd2;

    // fixed packet bytes and flags
    localparam logic [7:0] BIND_B4     = 8'h56;
    localparam logic [7:0] BIND_B5     = 8'hAA;
    localparam logic [7:0] BIND_B6     = 8'h32;
    localparam logic [7:0] FLAG_ROLL   = 8'h0F;
    localparam logic [7:0] FLAG_LAMP   = 8'h80;
    localparam logic [7:0] FLAG_PIC    = 8'h40;
    localparam logic [7:0] FLAG_REC    = 8'h20;
    localparam logic [7:0] FLAG_HLESS  = 8'h10;
    localparam logic [7:0] FILL_QUAD   = 8'h60;
    localparam logic [7:0] FILL_NIHUI  = 8'h64;
    localparam logic [7:0] FILL_OTHER  = 8'h65;

    typedef enum logic [2:0] {
        MODE_INIT        = 3'd0,
        MODE_BIND_REPEAT = 3'd1,
        MODE_BIND_WAIT   = 3'd2,
        MODE_DATA_WAIT   = 3'd3,
        MODE_DATA        = 3'd4
    } mode_t;

    typedef logic [PKT_BYTES-1:0][7:0] pkt_t;

    typedef struct packed {
        logic signed [15:0] throttle_in;
        logic signed [15:0] rudder_in;
        logic signed [15:0] elevator_in;
        logic signed [15:0] aileron_in;
        logic [4:0]         aux_switches;
        logic               tx_sent;
        logic               retries_exhausted;
    } tick_t;

    typedef struct packed {
        logic [7:0] thr;
        logic [7:0] rud;
        logic [7:0] ele;
        logic [7:0] ail;
        logic [4:0] aux;
        logic       tx_sent;
        logic       retries_exhausted;
    } scaled_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       byte_valid;
        logic       last;
        logic [1:0] addr_action;
        logic [7:0] bind_addr_byte;
        logic       disable_auto_ack;
        logic       wait_long;
        logic       bound;
    } result_t;

endpackage

@@ src/rc_bind_and_control_packet_sequencer.sv @@
// Top level of the RC bind and control packet sequencer: configuration registers,
// scaling stage and packet sequencer. Depends on rcbc_pkg and both submodules.
//
// One tick word in gives one to nine result words out, one per cycle while
// result_ready is high: a single status word when nothing is sent, eight packet
// bytes for the base variant and nine (with checksum) otherwise. A tick passes
// the input register, the scaled-stick register and then the packet register
// before its first result word; ticks are taken back to back while the stages
// downstream are free. The sustained tick rate is set by the output serialiser,
// which holds each tick until all of its result words have been taken. The next
// tick is already scaled and waiting while the previous packet drains.
module rc_bind_and_control_packet_sequencer
    import rcbc_pkg::*;
#(
    parameter int CHAN_FULL_SCALE = 10000,
    parameter int BIND_REPEATS    = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        tick_valid,
    output logic        tick_ready,
    input  tick_t       tick,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    logic [2:0]  variant_reg;
    logic [31:0] addr_reg;
    logic        scaled_valid;
    logic        scaled_ready;
    scaled_t     scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= VAR_BASE;
            addr_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VARIANT: variant_reg <= cfg_data[2:0];
                CFG_ADDRESS: addr_reg    <= cfg_data;
                default:     addr_reg    <= addr_reg;
            endcase
        end
    end

    rcbc_scale_stage #(
        .CHAN_FULL_SCALE(CHAN_FULL_SCALE)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .scaled_valid (scaled_valid),
        .scaled_ready (scaled_ready),
        .scaled       (scaled)
    );

    rcbc_packet_seq #(
        .BIND_REPEATS(BIND_REPEATS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .variant      (variant_reg),
        .data_address (addr_reg),
        .scaled_valid (scaled_valid),
        .scaled_ready (scaled_ready),
        .scaled       (scaled),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTHESIS
    // a packet never breaks off mid-burst
    a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last |=> result_valid)
        else $error("packet burst interrupted");

    // a status-only word stands alone and carries no byte
    a_wait_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.byte_valid |-> result.last && (result.packet_byte == 8'h00))
        else $error("status word malformed");

    // switching to the bind address always comes with a bind packet
    a_bind_switch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.addr_action == ADDR_BIND) |-> result.byte_valid
        && result.wait_long && !result.bound)
        else $error("bind address switch without packet");

    // auto-ack disable only on a tick that sends nothing and enters data mode
    a_noack: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.disable_auto_ack |-> !result.byte_valid && result.bound)
        else $error("auto-ack disable on wrong tick");
`endif

endmodule

@@ src/rcbc_scale_stage.sv @@
// Input register and stick scaling stage: clamps and scales four sticks to bytes.
// Depends on rcbc_pkg.
module rcbc_scale_stage
    import rcbc_pkg::*;
#(
    parameter int CHAN_FULL_SCALE = 10000
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tick_valid,
    output logic    tick_ready,
    input  tick_t   tick,
    output logic    scaled_valid,
    input  logic    scaled_ready,
    output scaled_t scaled
);

    // reciprocal scaling: exact while 2**K exceeds the full scale squared
    localparam int K  = 2 * $clog2(CHAN_FULL_SCALE + 1);
    localparam longint unsigned Recip =
        ((longint'(255) << K) + longint'(CHAN_FULL_SCALE) - 1) / CHAN_FULL_SCALE;
    localparam int MW = $clog2(CHAN_FULL_SCALE + 1);
    localparam int RW = $clog2(Recip + 1);
    localparam int PW = MW + RW;

    logic    a_valid_reg;
    tick_t   a_reg;
    logic    b_valid_reg;
    scaled_t b_reg;
    scaled_t b_next;
    logic    b_load;

    function automatic logic [7:0] scale_stick(logic signed [15:0] ch);
        logic          neg;
        logic [16:0]   mag;
        logic [MW-1:0] m;
        logic [PW-1:0] prod;
        logic [7:0]    q;
        logic [9:0]    v;
        neg = ch[15];
        mag = neg ? (17'd0 - {ch[15], ch}) : {1'b0, ch};
        if (mag > 17'(CHAN_FULL_SCALE))
        begin
            m = MW'(CHAN_FULL_SCALE);
        end
        else
        begin
            m = mag[MW-1:0];
        end
        prod = PW'(m) * PW'(Recip);
        q    = 8'(prod >> K);
        v    = neg ? (10'd256 - {2'b00, q}) : (10'd256 + {2'b00, q});
        return v[8:1];
    endfunction

    assign b_load       = a_valid_reg && (!b_valid_reg || scaled_ready);
    assign tick_ready   = !a_valid_reg || b_load;
    assign scaled_valid = b_valid_reg;
    assign scaled       = b_reg;

    always_comb
    begin
        b_next.thr               = scale_stick(a_reg.throttle_in);
        b_next.rud               = scale_stick(a_reg.rudder_in);
        b_next.ele               = scale_stick(a_reg.elevator_in);
        b_next.ail               = scale_stick(a_reg.aileron_in);
        b_next.aux               = a_reg.aux_switches;
        b_next.tx_sent           = a_reg.tx_sent;
        b_next.retries_exhausted = a_reg.retries_exhausted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_ready)
            begin
                a_valid_reg <= tick_valid;
            end
            if (b_load)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (scaled_ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            a_reg <= tick;
        end
        if (b_load)
        begin
            b_reg <= b_next;
        end
    end

endmodule

@@ src/rcbc_packet_seq.sv @@
// Mode machine, packet assembly and byte serialiser for one tick at a time.
// Depends on rcbc_pkg; fed by rcbc_scale_stage.
module rcbc_packet_seq
    import rcbc_pkg::*;
#(
    parameter int BIND_REPEATS = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  variant,
    input  logic [31:0] data_address,
    input  logic        scaled_valid,
    output logic        scaled_ready,
    input  scaled_t     scaled,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    localparam int CW = $clog2(BIND_REPEATS + 1);

    mode_t         mode_reg, mode_next;
    logic [CW-1:0] count_reg, count_next;

    pkt_t       pkt_reg;
    logic [3:0] cnt_reg;
    logic       valid_reg;
    logic       has_pkt_reg;
    logic [1:0] act_reg;
    logic [7:0] fill_reg;
    logic       noack_reg;
    logic       wlong_reg;
    logic       bound_reg;

    logic       load;
    logic       fire_last;
    logic       acked, timeout, pending;
    logic       send_ctrl, send_bind;
    logic [1:0] act;
    logic       noack, wlong;
    logic [7:0] rud_b, ail_b, flags, sum, fill;
    pkt_t       ctrl_pkt, bind_pkt, pkt_next;
    logic [3:0] cnt_next;

    assign fire_last    = result_valid && result_ready && (cnt_reg == 4'd1);
    assign scaled_ready = !valid_reg || fire_last;
    assign load         = scaled_valid && scaled_ready;

    // mode machine
    always_comb
    begin
        acked      = scaled.tx_sent;
        timeout    = !acked && scaled.retries_exhausted;
        pending    = !acked && !timeout;
        mode_next  = mode_reg;
        count_next = count_reg;
        send_ctrl  = 1'b0;
        send_bind  = 1'b0;
        act        = ADDR_NONE;
        noack      = 1'b0;
        wlong      = 1'b1;
        unique case (mode_reg)
            MODE_BIND_REPEAT:
            begin
                if (pending)
                begin
                    wlong = 1'b0;
                end
                else if (count_reg == '0)
                begin
                    act       = ADDR_DATA;
                    send_ctrl = 1'b1;
                    mode_next = MODE_DATA_WAIT;
                end
                else
                begin
                    send_bind  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            MODE_BIND_WAIT:
            begin
                if (pending)
                begin
                    wlong = 1'b0;
                end
                else if (acked)
                begin
                    mode_next = MODE_DATA;
                end
                else
                begin
                    act        = ADDR_BIND;
                    count_next = CW'(BIND_REPEATS);
                    mode_next  = MODE_BIND_REPEAT;
                    send_bind  = 1'b1;
                end
            end
            MODE_DATA_WAIT:
            begin
                if (pending)
                begin
                    wlong = 1'b0;
                end
                else
                begin
                    noack     = timeout;
                    mode_next = MODE_DATA;
                end
            end
            MODE_DATA:
            begin
                if (pending)
                begin
                    wlong = 1'b0;
                end
                else
                begin
                    send_ctrl = 1'b1;
                end
            end
            default:
            begin
                send_ctrl = 1'b1;
                mode_next = MODE_BIND_WAIT;
            end
        endcase
    end

    // packet assembly
    always_comb
    begin
        rud_b = (variant == VAR_WALKER || variant == VAR_XINX) ? scaled.rud : ~scaled.rud;
        ail_b = (variant == VAR_WALKER) ? scaled.ail : ~scaled.ail;
        flags = 8'h00;
        if (scaled.aux[0]) flags = flags | FLAG_ROLL;
        if (scaled.aux[1]) flags = flags | FLAG_LAMP;
        if (scaled.aux[2]) flags = flags | FLAG_PIC;
        if (scaled.aux[3]) flags = flags | FLAG_REC;
        if (scaled.aux[4]) flags = flags | FLAG_HLESS;

        ctrl_pkt    = '0;
        ctrl_pkt[0] = scaled.thr;
        ctrl_pkt[1] = rud_b;
        ctrl_pkt[3] = scaled.ele;
        ctrl_pkt[4] = ail_b;
        ctrl_pkt[7] = flags;
        if (variant == VAR_BASE)
        begin
            ctrl_pkt[6] = {1'b0, rud_b[7:1]};
            ctrl_pkt[2] = {1'b0, scaled.ele[7:1]};
            ctrl_pkt[5] = {1'b0, ail_b[7:1]};
        end
        else
        begin
            ctrl_pkt[2] = {1'b0, rud_b[7:1]};
            ctrl_pkt[5] = {1'b0, scaled.ele[7:1]};
            ctrl_pkt[6] = {1'b0, ail_b[7:1]};
        end

        bind_pkt    = '0;
        bind_pkt[0] = data_address[31:24];
        bind_pkt[1] = data_address[23:16];
        bind_pkt[2] = data_address[15:8];
        bind_pkt[3] = data_address[7:0];
        bind_pkt[4] = BIND_B4;
        bind_pkt[5] = BIND_B5;
        bind_pkt[6] = (variant == VAR_NIHUI) ? 8'h00 : BIND_B6;

        if (send_ctrl)
        begin
            pkt_next = ctrl_pkt;
        end
        else if (send_bind)
        begin
            pkt_next = bind_pkt;
        end
        else
        begin
            pkt_next = '0;
        end

        sum = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + pkt_next[i];
        end
        if (variant != VAR_BASE)
        begin
            pkt_next[8] = ~sum;
        end

        if (!(send_ctrl || send_bind))
        begin
            pkt_next = '0;
            cnt_next = 4'd1;
        end
        else if (variant == VAR_BASE)
        begin
            cnt_next = 4'd8;
        end
        else
        begin
            cnt_next = 4'd9;
        end

        priority if (variant == VAR_QUAD)
        begin
            fill = FILL_QUAD;
        end
        else if (variant == VAR_NIHUI)
        begin
            fill = FILL_NIHUI;
        end
        else
        begin
            fill = FILL_OTHER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_INIT;
            count_reg <= '0;
            valid_reg <= 1'b0;
            cnt_reg   <= 4'd1;
        end
        else if (load)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            valid_reg <= 1'b1;
            cnt_reg   <= cnt_next;
        end
        else if (result_valid && result_ready)
        begin
            if (cnt_reg == 4'd1)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkt_reg     <= pkt_next;
            has_pkt_reg <= send_ctrl || send_bind;
            act_reg     <= act;
            fill_reg    <= fill;
            noack_reg   <= noack;
            wlong_reg   <= wlong;
            bound_reg   <= (mode_next == MODE_DATA);
        end
        else if (result_valid && result_ready)
        begin
            pkt_reg <= {8'h00, pkt_reg[PKT_BYTES-1:1]};
        end
    end

    assign result_valid            = valid_reg;
    assign result.packet_byte      = pkt_reg[0];
    assign result.byte_valid       = has_pkt_reg;
    assign result.last             = (cnt_reg == 4'd1);
    assign result.addr_action      = act_reg;
    assign result.bind_addr_byte   = fill_reg;
    assign result.disable_auto_ack = noack_reg;
    assign result.wait_long        = wlong_reg;
    assign result.bound            = bound_reg;

endmodule

@@ tb/sv/tb_rc_bind_and_control_packet_sequencer.sv @@
// Self-checking testbench for rc_bind_and_control_packet_sequencer: a directed table,
// then randomised phases over all variants; each result word is checked against
// the table or a model. Depends on rcbc_pkg and the sequencer RTL in src.
module tb_rc_bind_and_control_packet_sequencer;
    import rcbc_pkg::*;

    localparam int FULL_SCALE   = 10000;
    localparam int REPEAT_COUNT = 60;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 30;
    localparam int PHASE_SETTLE = 4;
    localparam int END_SETTLE   = 24;

    // spare variant codes, treated like quad x4 but with the FILL_OTHER bind address byte
    localparam logic [2:0] VAR_SPARE_A = 3'd5;
    localparam logic [2:0] VAR_SPARE_B = 3'd6;
    localparam logic [2:0] VAR_SPARE_C = 3'd7;

    localparam logic [2:0] VARIANT_PLAN [PHASES] = '{VAR_NIHUI, VAR_SPARE_B, VAR_BASE,
        VAR_QUAD, VAR_WALKER, VAR_XINX, VAR_SPARE_A, VAR_SPARE_C, VAR_BASE, VAR_NIHUI};

    // byte 0 leftmost, so literals read in packet order
    typedef logic [0:PKT_BYTES-1][7:0] byte_row_t;

    typedef struct {
        tick_t      t;
        bit         known;
        int         len;
        byte_row_t  bytes;
        logic [1:0] act;
        logic [7:0] fill;
        bit         noack;
        bit         wlong;
        bit         bound;
    } tick_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        tick_valid;
    logic        tick_ready;
    tick_t       tick;
    logic        result_valid;
    logic        result_ready;
    result_t     result;

    logic [2:0]  model_variant;
    logic [31:0] model_address;
    mode_t       model_mode;
    logic [5:0]  model_binds_left;

    result_t     predicted_words [$];
    tick_row_t   tick_plan [$];
    int          mismatches = 0;
    int          word_index = 0;
    int          ready_hold = 0;
    int          ready_draw;
    bit          idle_on = 1'b1;

    rc_bind_and_control_packet_sequencer #(
        .CHAN_FULL_SCALE(FULL_SCALE),
        .BIND_REPEATS   (REPEAT_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick_valid  (tick_valid),
        .tick_ready  (tick_ready),
        .tick        (tick),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always #4 clk = ~clk;

    function automatic int draw_gap();
        if (!idle_on || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [7:0] scale_stick(logic signed [15:0] raw);
        int ch;
        int v;
        ch = int'(raw);
        if (ch < -FULL_SCALE)
            ch = -FULL_SCALE;
        if (ch > FULL_SCALE)
            ch = FULL_SCALE;
        v = (ch * 255) / FULL_SCALE + 256;
        return v[8:1];
    endfunction

    function automatic logic [7:0] fill_byte();
        if (model_variant == VAR_QUAD)
            return FILL_QUAD;
        if (model_variant == VAR_NIHUI)
            return FILL_NIHUI;
        return FILL_OTHER;
    endfunction

    function automatic byte_row_t control_bytes(tick_t t);
        byte_row_t  p;
        logic [7:0] thr;
        logic [7:0] rud;
        logic [7:0] ele;
        logic [7:0] ail;
        logic [7:0] fl;
        thr = scale_stick(t.throttle_in);
        rud = scale_stick(t.rudder_in);
        ele = scale_stick(t.elevator_in);
        ail = scale_stick(t.aileron_in);
        if (!(model_variant == VAR_XINX || model_variant == VAR_WALKER))
            rud = ~rud;
        if (model_variant != VAR_WALKER)
            ail = ~ail;
        fl = '0;
        if (t.aux_switches[0])
            fl |= FLAG_ROLL;
        if (t.aux_switches[1])
            fl |= FLAG_LAMP;
        if (t.aux_switches[2])
            fl |= FLAG_PIC;
        if (t.aux_switches[3])
            fl |= FLAG_REC;
        if (t.aux_switches[4])
            fl |= FLAG_HLESS;
        p = '0;
        p[0] = thr;
        p[1] = rud;
        p[3] = ele;
        p[4] = ail;
        p[7] = fl;
        if (model_variant == VAR_BASE)
        begin
            p[6] = rud >> 1;
            p[2] = ele >> 1;
            p[5] = ail >> 1;
        end
        else
        begin
            p[2] = rud >> 1;
            p[5] = ele >> 1;
            p[6] = ail >> 1;
        end
        return p;
    endfunction

    function automatic byte_row_t bind_bytes();
        byte_row_t p;
        p = '0;
        p[0] = model_address[31:24];
        p[1] = model_address[23:16];
        p[2] = model_address[15:8];
        p[3] = model_address[7:0];
        p[4] = BIND_B4;
        p[5] = BIND_B5;
        p[6] = (model_variant == VAR_NIHUI) ? 8'h00 : BIND_B6;
        return p;
    endfunction

    function automatic byte_row_t with_checksum(byte_row_t p);
        logic [7:0] sum;
        sum = '0;
        for (int k = 0; k < 8; k++)
            sum += p[k];
        p[8] = ~sum;
        return p;
    endfunction

    function automatic void queue_words(int len, byte_row_t pkt, logic [1:0] act,
                                        logic [7:0] fill, bit noack, bit wlong, bit bound);
        result_t w;
        int      n;
        n = (len > 0) ? len : 1;
        for (int k = 0; k < n; k++)
        begin
            w.packet_byte      = (len > 0) ? pkt[k] : 8'h00;
            w.byte_valid       = len > 0;
            w.last             = k == n - 1;
            w.addr_action      = act;
            w.bind_addr_byte   = fill;
            w.disable_auto_ack = noack;
            w.wait_long        = wlong;
            w.bound            = bound;
            predicted_words.push_back(w);
        end
    endfunction

    // advances the mode machine by one tick; keep queues the words it predicts
    function automatic void compute_tick_words(tick_t t, bit keep);
        byte_row_t  pkt;
        logic [1:0] act;
        bit         acked;
        bit         gave_up;
        bit         waiting;
        bit         noack;
        bit         wlong;
        bit         sends;
        pkt     = '0;
        act     = ADDR_NONE;
        noack   = 1'b0;
        wlong   = 1'b1;
        sends   = 1'b0;
        acked   = t.tx_sent;
        gave_up = !t.tx_sent && t.retries_exhausted;
        waiting = !acked && !gave_up;
        case (model_mode)
            MODE_BIND_REPEAT:
            begin
                if (waiting)
                    wlong = 1'b0;
                else if (model_binds_left == 0)
                begin
                    act        = ADDR_DATA;
                    pkt        = control_bytes(t);
                    sends      = 1'b1;
                    model_mode = MODE_DATA_WAIT;
                end
                else
                begin
                    pkt              = bind_bytes();
                    sends            = 1'b1;
                    model_binds_left = model_binds_left - 6'd1;
                end
            end
            MODE_BIND_WAIT:
            begin
                if (waiting)
                    wlong = 1'b0;
                else if (acked)
                    model_mode = MODE_DATA;
                else
                begin
                    act              = ADDR_BIND;
                    model_binds_left = 6'(REPEAT_COUNT);
                    model_mode       = MODE_BIND_REPEAT;
                    pkt              = bind_bytes();
                    sends            = 1'b1;
                end
            end
            MODE_DATA_WAIT:
            begin
                if (waiting)
                    wlong = 1'b0;
                else
                begin
                    noack      = gave_up;
                    model_mode = MODE_DATA;
                end
            end
            MODE_DATA:
            begin
                if (waiting)
                    wlong = 1'b0;
                else
                begin
                    pkt   = control_bytes(t);
                    sends = 1'b1;
                end
            end
            default:
            begin
                pkt        = control_bytes(t);
                sends      = 1'b1;
                model_mode = MODE_BIND_WAIT;
            end
        endcase
        if (keep)
            queue_words(!sends ? 0 : (model_variant == VAR_BASE) ? 8 : 9, with_checksum(pkt),
                        act, fill_byte(), noack, wlong, model_mode == MODE_DATA);
    endfunction

    function automatic tick_t mk_tick(int thr, int rud, int ele, int ail, int aux,
                                      bit sent, bit gave_up);
        tick_t t;
        t.throttle_in       = 16'(thr);
        t.rudder_in         = 16'(rud);
        t.elevator_in       = 16'(ele);
        t.aileron_in        = 16'(ail);
        t.aux_switches      = 5'(aux);
        t.tx_sent           = sent;
        t.retries_exhausted = gave_up;
        return t;
    endfunction

    function automatic void add_row(tick_t t);
        tick_plan.push_back('{t, 1'b0, 0, '0, ADDR_NONE, FILL_OTHER, 1'b0, 1'b0, 1'b0});
    endfunction

    function automatic void add_known(tick_t t, int len, byte_row_t b, logic [1:0] act,
                                      logic [7:0] fill, bit noack, bit wlong, bit bound);
        tick_plan.push_back('{t, 1'b1, len, b, act, fill, noack, wlong, bound});
    endfunction

    function automatic logic signed [15:0] pick_stick();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 65535);
            1: v = int'($urandom_range(0, 20000)) - 10000;
            2:
            begin
                case ($urandom_range(0, 9))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -10001;
                    3: v = -10000;
                    4: v = -9999;
                    5: v = -1;
                    6: v = 0;
                    7: v = 1;
                    8: v = 10000;
                    default: v = 10001;
                endcase
            end
            default: v = int'($urandom_range(0, 600)) - 300;
        endcase
        return 16'(v);
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int    status;
        t.throttle_in       = pick_stick();
        t.rudder_in         = pick_stick();
        t.elevator_in       = pick_stick();
        t.aileron_in        = pick_stick();
        t.aux_switches      = 5'($urandom_range(0, 31));
        status              = $urandom_range(0, 9);
        t.tx_sent           = (status >= 4 && status <= 6) || status == 9;
        t.retries_exhausted = status >= 7;
        return t;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("word %0d: %s is %0h, %0h awaited", word_index, field, got, want);
    endtask

    task automatic check_word(result_t got);
        result_t want;
        word_index++;
        if (predicted_words.size() == 0)
        begin
            report_mismatch("word with nothing awaited, packet_byte",
                            32'(got.packet_byte), 32'd0);
            return;
        end
        want = predicted_words.pop_front();
        if (got.packet_byte !== want.packet_byte)
            report_mismatch("packet_byte", 32'(got.packet_byte), 32'(want.packet_byte));
        if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
        if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
        if (got.addr_action !== want.addr_action)
            report_mismatch("addr_action", 32'(got.addr_action), 32'(want.addr_action));
        if (got.bind_addr_byte !== want.bind_addr_byte)
            report_mismatch("bind_addr_byte", 32'(got.bind_addr_byte),
                            32'(want.bind_addr_byte));
        if (got.disable_auto_ack !== want.disable_auto_ack)
            report_mismatch("disable_auto_ack", 32'(got.disable_auto_ack),
                            32'(want.disable_auto_ack));
        if (got.wait_long !== want.wait_long)
            report_mismatch("wait_long", 32'(got.wait_long), 32'(want.wait_long));
        if (got.bound !== want.bound)
            report_mismatch("bound", 32'(got.bound), 32'(want.bound));
    endtask

    // result side: a fresh random stall may follow each accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                check_word(result);
                ready_draw = draw_gap();
                if (ready_draw != 0)
                begin
                    result_ready <= 1'b0;
                    ready_hold   <= ready_draw;
                end
            end
            else if (!result_ready)
            begin
                if (ready_hold <= 1)
                    result_ready <= 1'b1;
                ready_hold <= ready_hold - 1;
            end
        end
    end

    // called at a clock edge; leaves the write enable low
    task automatic program_registers(logic [2:0] variant, logic [31:0] address);
        logic [31:0] noise;
        noise = $urandom();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VARIANT;
        cfg_data  <= {noise[31:3], variant};
        @(posedge clk);
        cfg_index <= CFG_ADDRESS;
        cfg_data  <= address;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_variant = variant;
        model_address = address;
    endtask

    task automatic send_tick(tick_t t);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        do @(posedge clk); while (!tick_ready);
    endtask

    task automatic drain_words(int settle);
        tick_valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    initial
    begin
        tick_t t;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_VARIANT;
        cfg_data     <= '0;
        tick_valid   <= 1'b0;
        tick         <= '0;
        result_ready <= 1'b1;
        model_variant    = VAR_BASE;
        model_address    = '0;
        model_mode       = MODE_INIT;
        model_binds_left = '0;

        // initial control packet with clamped sticks and all flags, bind-wait, bind entry
        add_known(mk_tick(32767, -32768, 10001, -10001, 31, 1'b0, 1'b0), 8,
                  {8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'hFF, 8'h00},
                  ADDR_NONE, FILL_OTHER, 1'b0, 1'b1, 1'b0);
        add_known(mk_tick(0, 0, 0, 0, 0, 1'b0, 1'b0), 0, '0,
                  ADDR_NONE, FILL_OTHER, 1'b0, 1'b0, 1'b0);
        add_known(mk_tick(0, 0, 0, 0, 0, 1'b0, 1'b1), 8,
                  {8'h01, 8'h02, 8'h03, 8'h04, 8'h56, 8'hAA, 8'h32, 8'h00, 8'h00},
                  ADDR_BIND, FILL_OTHER, 1'b0, 1'b1, 1'b0);
        add_known(mk_tick(0, 0, 0, 0, 0, 1'b0, 1'b0), 0, '0,
                  ADDR_NONE, FILL_OTHER, 1'b0, 1'b0, 1'b0);
        // bind repeats; sent wins over retries exhausted
        add_row(mk_tick(0, 0, 0, 0, 0, 1'b1, 1'b1));
        add_row(mk_tick(-1, 1, -10000, 10000, 1, 1'b1, 1'b0));
        add_row(mk_tick(1, -1, 9999, -9999, 2, 1'b0, 1'b1));
        add_row(mk_tick(32767, 32767, 32767, 32767, 4, 1'b0, 1'b0));
        add_row(mk_tick(-32768, -32768, -32768, -32768, 8, 1'b1, 1'b0));
        add_row(mk_tick(10001, -10001, 40, -40, 16, 1'b0, 1'b1));
        add_row(mk_tick(-39, 39, -41, 41, 31, 1'b1, 1'b1));
        add_row(mk_tick(0, 0, 0, 0, 0, 1'b0, 1'b0));
        add_row(mk_tick(-10001, 10001, -32768, 32767, 21, 1'b1, 1'b0));
        add_row(mk_tick(255, -255, 5000, -5000, 10, 1'b0, 1'b1));
        add_row(mk_tick(-20000, 20000, 12345, -12345, 0, 1'b1, 1'b0));
        add_row(mk_tick(7, -7, 77, -77, 31, 1'b0, 1'b1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        program_registers(VAR_BASE, 32'h0102_0304);

        foreach (tick_plan[i])
        begin
            send_tick(tick_plan[i].t);
            compute_tick_words(tick_plan[i].t, !tick_plan[i].known);
            if (tick_plan[i].known)
                queue_words(tick_plan[i].len, tick_plan[i].bytes, tick_plan[i].act,
                            tick_plan[i].fill, tick_plan[i].noack, tick_plan[i].wlong,
                            tick_plan[i].bound);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_words(PHASE_SETTLE);
            idle_on = (p % 3) != 1;
            program_registers(VARIANT_PLAN[p],
                              (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'h0 : $urandom());
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                t = random_tick();
                send_tick(t);
                compute_tick_words(t, 1'b1);
            end
        end

        drain_words(END_SETTLE);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/rcbc_pkg.sv
src/rcbc_scale_stage.sv
src/rcbc_packet_seq.sv
src/rc_bind_and_control_packet_sequencer.sv
tb/sv/tb_rc_bind_and_control_packet_sequencer.sv
